// ===== rtl/ula_pkg.sv =====
// Shared types and constants for the UART line assembler.
package ula_pkg;

    localparam int ULA_RX_DEPTH  = 64;
    localparam int ULA_MSG_DEPTH = 64;

    // results kept per input transfer; later ones are dropped
    localparam int RESULT_LIMIT = 63;
    localparam int RES_CNT_W    = 6;

    localparam logic [7:0] TERM_RESET = 8'h0A;

    localparam logic [0:0] REG_TERMINATOR = 1'b0;

    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    localparam logic [1:0] KIND_MSG   = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRN_CHK,
        ST_DRN_WR,
        ST_PULL_CHK,
        ST_PULL_EMIT,
        ST_FINISH
    } ula_state_t;

endpackage

// ===== rtl/uart_line_assembler_core.sv =====
// UART receive line assembler: error counting, receive ring, message ring, message output.
// One item at a time: s_tready is high only in the idle state. An error byte or a clear gives
// one result, held back and then moved to the output register; a plain byte other than the
// terminator gives none. A terminator drains the receive ring into the message ring and reads
// out one message, or an empty marker, per drained terminator. Output back-pressure can stall.
// Reset clears pointers, counters and control; terminator returns to 0x0A; ring data is kept.
module uart_line_assembler_core #(
    parameter int RX_DEPTH  = ula_pkg::ULA_RX_DEPTH,
    parameter int MSG_DEPTH = ula_pkg::ULA_MSG_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // rx_byte[7:0], frame_error[8], overrun_error[9],
                                  // parity_error[10], zero[15:11]
    input  logic [0:0]  s_tuser,  // action[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // msg_byte[7:0], byte_valid[8], flag_bits[11:9],
                                  // frame_count[27:12], overrun_count[43:28],
                                  // parity_count[59:44], zero[63:60]
    output logic [1:0]  m_tuser,  // kind[1:0]
    output logic        m_tlast
);
    import ula_pkg::*;

    localparam int RPW = $clog2(RX_DEPTH);
    localparam int MPW = $clog2(MSG_DEPTH);

    ula_state_t state_reg, state_next;

    logic [7:0]     rx_mem  [RX_DEPTH];
    logic [7:0]     msg_mem [MSG_DEPTH];

    logic [RPW-1:0] rx_wr_reg, rx_wr_next, rx_rd_reg, rx_rd_next;
    logic [MPW-1:0] msg_wr_reg, msg_wr_next, msg_rd_reg, msg_rd_next;
    logic [RPW-1:0] rx_wr_inc, rx_rd_inc;
    logic [MPW-1:0] msg_wr_inc, msg_rd_inc;
    logic [15:0]    frame_cnt_reg, frame_cnt_next;
    logic [15:0]    overrun_cnt_reg, overrun_cnt_next;
    logic [15:0]    parity_cnt_reg, parity_cnt_next;
    logic [7:0]     term_reg;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic [MPW-1:0] pull_cnt_reg, pull_cnt_next;
    logic [7:0]     rx_q_reg, msg_q_reg;
    logic           rx_we, rx_re, msg_we, msg_re;

    // one result held back so that the final one can carry tlast
    logic           pend_valid_reg, pend_valid_next;
    logic [1:0]     pend_kind_reg, pend_kind_next;
    logic [7:0]     pend_byte_reg, pend_byte_next;
    logic           pend_bvalid_reg, pend_bvalid_next;
    logic [2:0]     pend_flags_reg, pend_flags_next;

    logic           out_valid_reg, out_valid_next;
    logic [1:0]     out_kind_reg, out_kind_next;
    logic [7:0]     out_byte_reg, out_byte_next;
    logic           out_bvalid_reg, out_bvalid_next;
    logic           out_last_reg, out_last_next;
    logic [2:0]     out_flags_reg, out_flags_next;
    logic [15:0]    out_fcnt_reg, out_fcnt_next;
    logic [15:0]    out_ocnt_reg, out_ocnt_next;
    logic [15:0]    out_pcnt_reg, out_pcnt_next;

    logic           gen_req, flush, slot_free, keep, can_gen;
    logic [1:0]     gen_kind;
    logic [7:0]     gen_byte;
    logic           gen_bvalid;
    logic [2:0]     gen_flags;
    logic [2:0]     in_flags;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_TERMINATOR) ? {24'd0, term_reg} : 32'd0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_pcnt_reg, out_ocnt_reg, out_fcnt_reg, out_flags_reg,
                       out_bvalid_reg, out_byte_reg};

    assign rx_wr_inc  = (rx_wr_reg == RPW'(RX_DEPTH - 1)) ? '0 : rx_wr_reg + 1'b1;
    assign rx_rd_inc  = (rx_rd_reg == RPW'(RX_DEPTH - 1)) ? '0 : rx_rd_reg + 1'b1;
    assign msg_wr_inc = (msg_wr_reg == MPW'(MSG_DEPTH - 1)) ? '0 : msg_wr_reg + 1'b1;
    assign msg_rd_inc = (msg_rd_reg == MPW'(MSG_DEPTH - 1)) ? '0 : msg_rd_reg + 1'b1;

    assign in_flags  = s_tdata[10:8];
    assign slot_free = !pend_valid_reg || !out_valid_reg || m_tready;
    assign keep      = (res_cnt_reg < RES_CNT_W'(RESULT_LIMIT));
    assign can_gen   = !keep || slot_free;

    always_ff @(posedge aclk) begin
        if (rx_we) begin
            rx_mem[rx_wr_reg] <= s_tdata[7:0];
        end
        if (rx_re) begin
            rx_q_reg <= rx_mem[rx_rd_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (msg_we) begin
            msg_mem[msg_wr_reg] <= rx_q_reg;
        end
        if (msg_re) begin
            msg_q_reg <= msg_mem[msg_rd_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_reg <= TERM_RESET;
        end else if (psel && penable && pwrite && pready && paddr == REG_TERMINATOR) begin
            term_reg <= pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_wr_reg       <= '0;
            rx_rd_reg       <= '0;
            msg_wr_reg      <= '0;
            msg_rd_reg      <= '0;
            frame_cnt_reg   <= '0;
            overrun_cnt_reg <= '0;
            parity_cnt_reg  <= '0;
            res_cnt_reg     <= '0;
            pull_cnt_reg    <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            rx_wr_reg       <= rx_wr_next;
            rx_rd_reg       <= rx_rd_next;
            msg_wr_reg      <= msg_wr_next;
            msg_rd_reg      <= msg_rd_next;
            frame_cnt_reg   <= frame_cnt_next;
            overrun_cnt_reg <= overrun_cnt_next;
            parity_cnt_reg  <= parity_cnt_next;
            res_cnt_reg     <= res_cnt_next;
            pull_cnt_reg    <= pull_cnt_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_kind_reg   <= pend_kind_next;
        pend_byte_reg   <= pend_byte_next;
        pend_bvalid_reg <= pend_bvalid_next;
        pend_flags_reg  <= pend_flags_next;
        out_kind_reg    <= out_kind_next;
        out_byte_reg    <= out_byte_next;
        out_bvalid_reg  <= out_bvalid_next;
        out_last_reg    <= out_last_next;
        out_flags_reg   <= out_flags_next;
        out_fcnt_reg    <= out_fcnt_next;
        out_ocnt_reg    <= out_ocnt_next;
        out_pcnt_reg    <= out_pcnt_next;
    end

    always_comb begin
        state_next       = state_reg;
        rx_wr_next       = rx_wr_reg;
        rx_rd_next       = rx_rd_reg;
        msg_wr_next      = msg_wr_reg;
        msg_rd_next      = msg_rd_reg;
        frame_cnt_next   = frame_cnt_reg;
        overrun_cnt_next = overrun_cnt_reg;
        parity_cnt_next  = parity_cnt_reg;
        res_cnt_next     = res_cnt_reg;
        pull_cnt_next    = pull_cnt_reg;
        rx_we            = 1'b0;
        rx_re            = 1'b0;
        msg_we           = 1'b0;
        msg_re           = 1'b0;
        gen_req          = 1'b0;
        gen_kind         = KIND_MSG;
        gen_byte         = 8'd0;
        gen_bvalid       = 1'b0;
        gen_flags        = 3'd0;
        flush            = 1'b0;

        pend_valid_next  = pend_valid_reg;
        pend_kind_next   = pend_kind_reg;
        pend_byte_next   = pend_byte_reg;
        pend_bvalid_next = pend_bvalid_reg;
        pend_flags_next  = pend_flags_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_kind_next    = out_kind_reg;
        out_byte_next    = out_byte_reg;
        out_bvalid_next  = out_bvalid_reg;
        out_last_next    = out_last_reg;
        out_flags_next   = out_flags_reg;
        out_fcnt_next    = out_fcnt_reg;
        out_ocnt_next    = out_ocnt_reg;
        out_pcnt_next    = out_pcnt_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_FINISH;
                    if (s_tuser[0] == ACT_CLEAR) begin
                        frame_cnt_next   = '0;
                        overrun_cnt_next = '0;
                        parity_cnt_next  = '0;
                        gen_req          = 1'b1;
                        gen_kind         = KIND_CLEAR;
                    end else if (in_flags != 3'd0) begin
                        frame_cnt_next   = frame_cnt_reg + 16'(in_flags[0]);
                        overrun_cnt_next = overrun_cnt_reg + 16'(in_flags[1]);
                        parity_cnt_next  = parity_cnt_reg + 16'(in_flags[2]);
                        gen_req          = 1'b1;
                        gen_kind         = KIND_ERROR;
                        gen_flags        = in_flags;
                        rx_wr_next       = '0;
                        rx_rd_next       = '0;
                    end else begin
                        if (rx_wr_inc != rx_rd_reg) begin
                            rx_we      = 1'b1;
                            rx_wr_next = rx_wr_inc;
                        end
                        if (s_tdata[7:0] == term_reg) begin
                            state_next = ST_DRN_CHK;
                        end
                    end
                end
            end
            ST_DRN_CHK: begin
                if (rx_rd_reg != rx_wr_reg) begin
                    rx_re      = 1'b1;
                    rx_rd_next = rx_rd_inc;
                    state_next = ST_DRN_WR;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_DRN_WR: begin
                // full message ring drops the byte but it still counts as a terminator
                if (msg_wr_inc != msg_rd_reg) begin
                    msg_we      = 1'b1;
                    msg_wr_next = msg_wr_inc;
                end
                if (rx_q_reg == term_reg) begin
                    pull_cnt_next = '0;
                    state_next    = ST_PULL_CHK;
                end else begin
                    state_next = ST_DRN_CHK;
                end
            end
            ST_PULL_CHK: begin
                if (msg_rd_reg != msg_wr_reg) begin
                    msg_re        = 1'b1;
                    msg_rd_next   = msg_rd_inc;
                    pull_cnt_next = pull_cnt_reg + 1'b1;
                    state_next    = ST_PULL_EMIT;
                end else if (pull_cnt_reg == '0) begin
                    // empty marker
                    gen_req = 1'b1;
                    if (can_gen) begin
                        state_next = ST_DRN_CHK;
                    end
                end else begin
                    state_next = ST_DRN_CHK;
                end
            end
            ST_PULL_EMIT: begin
                gen_req    = 1'b1;
                gen_byte   = msg_q_reg;
                gen_bvalid = 1'b1;
                if (can_gen) begin
                    if (msg_q_reg == term_reg || pull_cnt_reg >= MPW'(MSG_DEPTH - 1)) begin
                        state_next = ST_DRN_CHK;
                    end else begin
                        state_next = ST_PULL_CHK;
                    end
                end
            end
            ST_FINISH: begin
                if (!pend_valid_reg || !out_valid_reg || m_tready) begin
                    flush        = pend_valid_reg;
                    res_cnt_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a new result pushes the held one out with tlast low
        if (gen_req && keep && slot_free) begin
            res_cnt_next = res_cnt_reg + 1'b1;
            if (pend_valid_reg) begin
                out_valid_next  = 1'b1;
                out_kind_next   = pend_kind_reg;
                out_byte_next   = pend_byte_reg;
                out_bvalid_next = pend_bvalid_reg;
                out_flags_next  = pend_flags_reg;
                out_last_next   = 1'b0;
                out_fcnt_next   = frame_cnt_reg;
                out_ocnt_next   = overrun_cnt_reg;
                out_pcnt_next   = parity_cnt_reg;
            end
            pend_valid_next  = 1'b1;
            pend_kind_next   = gen_kind;
            pend_byte_next   = gen_byte;
            pend_bvalid_next = gen_bvalid;
            pend_flags_next  = gen_flags;
        end

        if (flush) begin
            out_valid_next  = 1'b1;
            out_kind_next   = pend_kind_reg;
            out_byte_next   = pend_byte_reg;
            out_bvalid_next = pend_bvalid_reg;
            out_flags_next  = pend_flags_reg;
            out_last_next   = 1'b1;
            out_fcnt_next   = frame_cnt_reg;
            out_ocnt_next   = overrun_cnt_reg;
            out_pcnt_next   = parity_cnt_reg;
            pend_valid_next = 1'b0;
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for uart_line_assembler_core: directed rows, then random lines.
module tb_top;
    import ula_pkg::*;

    localparam logic [2:0] FLG_NONE    = 3'b000;
    localparam logic [2:0] FLG_FRAME   = 3'b001;
    localparam logic [2:0] FLG_OVERRUN = 3'b010;
    localparam logic [2:0] FLG_PARITY  = 3'b100;
    localparam logic [2:0] FLG_ALL     = 3'b111;
    localparam int         SETTLE_CYC  = 300;
    localparam int         N_ROWS      = 24;

    typedef struct packed {
        logic [3:0]  pad;
        logic [15:0] parity_cnt;
        logic [15:0] overrun_cnt;
        logic [15:0] frame_cnt;
        logic [2:0]  flag_bits;
        logic        byte_valid;
        logic [7:0]  msg_byte;
        logic [1:0]  kind;
        logic        last;
    } line_result_t;

    typedef enum logic { ROW_XFER, ROW_SETTERM } row_op_t;

    typedef struct packed {
        row_op_t     op;
        logic        act;
        logic [7:0]  data;
        logic [2:0]  errs;
        logic        typed;
        logic [1:0]  t_kind;
        logic [2:0]  t_flags;
        logic [15:0] t_f;
        logic [15:0] t_o;
        logic [15:0] t_p;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;  // rx_byte[7:0], frame_error[8], overrun_error[9], parity_error[10]
    logic [0:0]  s_tuser;  // action[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;  // msg_byte[7:0], byte_valid[8], flag_bits[11:9], frame_count[27:12],
                           // overrun_count[43:28], parity_count[59:44]
    logic [1:0]  m_tuser;  // kind[1:0]
    logic        m_tlast;

    uart_line_assembler_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // line assembler model state
    logic [7:0]   term_m;
    logic [7:0]   rx_mem [ULA_RX_DEPTH];
    int           rx_wp, rx_rp;
    logic [7:0]   msg_mem [ULA_MSG_DEPTH];
    int           msg_wp, msg_rp;
    logic [15:0]  frame_m, overrun_m, parity_m;

    line_result_t line_out [$];
    line_result_t expected_q [$];
    line_result_t mon_got, mon_want;
    stim_row_t    dir_rows [0:N_ROWS-1];
    bit           gaps_on;
    int           errors;
    int           xfers_sent;
    int           results_checked;

    function automatic void push_line_result(logic [1:0] k, logic [7:0] b, logic v,
                                             logic [2:0] f);
        line_result_t r;
        if (line_out.size() >= RESULT_LIMIT) return;
        r = '0;
        r.kind        = k;
        r.msg_byte    = b;
        r.byte_valid  = v;
        r.flag_bits   = f;
        r.frame_cnt   = frame_m;
        r.overrun_cnt = overrun_m;
        r.parity_cnt  = parity_m;
        line_out.push_back(r);
    endfunction

    function automatic void predict_line(logic act, logic [7:0] b, logic [2:0] errs);
        int           cnt;
        bit           stop;
        logic [7:0]   c, d;
        line_result_t r;
        line_out.delete();
        if (act == ACT_CLEAR) begin
            frame_m   = '0;
            overrun_m = '0;
            parity_m  = '0;
            push_line_result(KIND_CLEAR, 8'h00, 1'b0, FLG_NONE);
        end else if (errs != FLG_NONE) begin
            if (errs[0]) frame_m++;
            if (errs[1]) overrun_m++;
            if (errs[2]) parity_m++;
            push_line_result(KIND_ERROR, 8'h00, 1'b0, errs);
            rx_wp = 0;
            rx_rp = 0;
        end else begin
            if ((rx_wp + 1) % ULA_RX_DEPTH != rx_rp) begin
                rx_mem[rx_wp] = b;
                rx_wp = (rx_wp + 1) % ULA_RX_DEPTH;
            end
            if (b == term_m) begin
                while (rx_rp != rx_wp) begin
                    d = rx_mem[rx_rp];
                    rx_rp = (rx_rp + 1) % ULA_RX_DEPTH;
                    if ((msg_wp + 1) % ULA_MSG_DEPTH != msg_rp) begin
                        msg_mem[msg_wp] = d;
                        msg_wp = (msg_wp + 1) % ULA_MSG_DEPTH;
                    end
                    // every drained terminator pulls one message
                    if (d == term_m) begin
                        cnt  = 0;
                        stop = 1'b0;
                        while (msg_rp != msg_wp && !stop) begin
                            c = msg_mem[msg_rp];
                            msg_rp = (msg_rp + 1) % ULA_MSG_DEPTH;
                            push_line_result(KIND_MSG, c, 1'b1, FLG_NONE);
                            cnt++;
                            stop = (c == term_m) || (cnt >= ULA_MSG_DEPTH - 1);
                        end
                        if (cnt == 0) push_line_result(KIND_MSG, 8'h00, 1'b0, FLG_NONE);
                    end
                end
            end
        end
        if (line_out.size() > 0) begin
            r = line_out.pop_back();
            r.last = 1'b1;
            line_out.push_back(r);
        end
    endfunction

    function automatic logic [7:0] rand_byte_except(logic [7:0] a, logic [7:0] b);
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255)); while (v == a || v == b);
        return v;
    endfunction

    task automatic send_xfer(input logic act, input logic [7:0] b, input logic [2:0] errs,
                             input logic typed = 1'b0, input line_result_t typed_res = '0);
        while (gaps_on && $urandom_range(0, 99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'd0, errs, b};
        do @(posedge aclk); while (!s_tready);
        predict_line(act, b, errs);
        if (typed) expected_q.push_back(typed_res);
        else foreach (line_out[i]) expected_q.push_back(line_out[i]);
        xfers_sent++;
    endtask

    task automatic apb_access(input logic wr, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_TERMINATOR;
        pwdata  <= {24'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (wr) begin
            term_m = val;
        end else if (prdata !== {24'd0, val}) begin
            $display("%0t: terminator read expected %h got %h", $time, {24'd0, val}, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic set_terminator(input logic [7:0] val);
        wait_drained();
        apb_access(1'b1, val);
        apb_access(1'b0, val);
    endtask

    always @(posedge aclk)
        m_tready <= (gaps_on && $urandom_range(0, 99) < 28) ? 1'b0 : 1'b1;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            mon_got             = '0;
            mon_got.pad         = m_tdata[63:60];
            mon_got.parity_cnt  = m_tdata[59:44];
            mon_got.overrun_cnt = m_tdata[43:28];
            mon_got.frame_cnt   = m_tdata[27:12];
            mon_got.flag_bits   = m_tdata[11:9];
            mon_got.byte_valid  = m_tdata[8];
            mon_got.msg_byte    = m_tdata[7:0];
            mon_got.kind        = m_tuser;
            mon_got.last        = m_tlast;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected transfer kind=%0d byte=%h", $time, mon_got.kind,
                         mon_got.msg_byte);
                errors++;
            end else begin
                mon_want = expected_q.pop_front();
                results_checked++;
                if (mon_got !== mon_want) begin
                    $display("%0t: expected kind=%0d byte=%h vld=%b last=%b flg=%0d cnt=%h/%h/%h pad=%h",
                             $time, mon_want.kind, mon_want.msg_byte, mon_want.byte_valid,
                             mon_want.last, mon_want.flag_bits, mon_want.frame_cnt,
                             mon_want.overrun_cnt, mon_want.parity_cnt, mon_want.pad);
                    $display("%0t:   actual kind=%0d byte=%h vld=%b last=%b flg=%0d cnt=%h/%h/%h pad=%h",
                             $time, mon_got.kind, mon_got.msg_byte, mon_got.byte_valid,
                             mon_got.last, mon_got.flag_bits, mon_got.frame_cnt,
                             mon_got.overrun_cnt, mon_got.parity_cnt, mon_got.pad);
                    errors++;
                end
            end
        end
    end

    initial begin
        #30_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        line_result_t row_res;
        logic [7:0]   next_term;
        logic [7:0]   b;
        int           sent_ph;
        int           pick;
        int           len;

        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= REG_TERMINATOR;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ACT_BYTE;
        m_tready <= 1'b0;
        gaps_on         = 1'b1;
        errors          = 0;
        xfers_sent      = 0;
        results_checked = 0;
        term_m    = TERM_RESET;
        rx_wp     = 0;
        rx_rp     = 0;
        msg_wp    = 0;
        msg_rp    = 0;
        frame_m   = '0;
        overrun_m = '0;
        parity_m  = '0;

        // typed rows carry the single result: kind, flags, frame/overrun/parity counts
        dir_rows = '{
            '{ROW_XFER, ACT_CLEAR, 8'hFF, FLG_ALL, 1'b1, KIND_CLEAR, FLG_NONE, 16'd0, 16'd0, 16'd0},
            '{ROW_XFER, ACT_BYTE, 8'h00, FLG_FRAME, 1'b1, KIND_ERROR, FLG_FRAME,
              16'd1, 16'd0, 16'd0},
            '{ROW_XFER, ACT_BYTE, 8'h00, FLG_OVERRUN, 1'b1, KIND_ERROR, FLG_OVERRUN,
              16'd1, 16'd1, 16'd0},
            '{ROW_XFER, ACT_BYTE, 8'hFF, FLG_PARITY, 1'b1, KIND_ERROR, FLG_PARITY,
              16'd1, 16'd1, 16'd1},
            '{ROW_XFER, ACT_BYTE, 8'hFF, FLG_ALL, 1'b1, KIND_ERROR, FLG_ALL, 16'd2, 16'd2, 16'd2},
            '{ROW_XFER, ACT_BYTE, 8'h48, FLG_NONE, 1'b0, KIND_MSG, FLG_NONE, 16'd0, 16'd0, 16'd0},
            '{ROW_XFER, ACT_BYTE, 8'h69, FLG_NONE, 1'b0, KIND_MSG, FLG_NONE, 16'd0, 16'd0, 16'd0},
            '{ROW_XFER, ACT_BYTE, 8'h0A, FLG_NONE, 1'b0, KIND_MSG, FLG_NONE, 16'd0, 16'd0, 16'd0},
            '{ROW_XFER, ACT_BYTE, 8'hFF, FLG_NONE, 1'b0, KIND_MSG, FLG_NONE, 16'd0, 16'd0, 16'd0},
            '{ROW_XFER, ACT_BYTE, 8'h00, FLG_NONE, 1'b0, KIND_MSG, FLG_NONE, 16'd0, 16'd0, 16'd0},
            // error drops the pending receive bytes
            '{ROW_XFER, ACT_BYTE, 8'h3C, FLG_FRAME | FLG_PARITY, 1'b1, KIND_ERROR,
              FLG_FRAME | FLG_PARITY, 16'd3, 16'd2, 16'd3},
            '{ROW_XFER, ACT_BYTE, 8'h0A, FLG_NONE, 1'b0, KIND_MSG, FLG_NONE, 16'd0, 16'd0, 16'd0},
            '{ROW_XFER, ACT_CLEAR, 8'h00, FLG_NONE, 1'b1, KIND_CLEAR, FLG_NONE,
              16'd0, 16'd0, 16'd0},
            '{ROW_XFER, ACT_BYTE, 8'h55, FLG_NONE, 1'b0, KIND_MSG, FLG_NONE, 16'd0, 16'd0, 16'd0},
            '{ROW_XFER, ACT_BYTE, 8'h0A, FLG_NONE, 1'b0, KIND_MSG, FLG_NONE, 16'd0, 16'd0, 16'd0},
            '{ROW_SETTERM, ACT_BYTE, 8'h00, FLG_NONE, 1'b0, KIND_MSG, FLG_NONE,
              16'd0, 16'd0, 16'd0},
            '{ROW_XFER, ACT_BYTE, 8'h41, FLG_NONE, 1'b0, KIND_MSG, FLG_NONE, 16'd0, 16'd0, 16'd0},
            '{ROW_XFER, ACT_BYTE, 8'h00, FLG_NONE, 1'b0, KIND_MSG, FLG_NONE, 16'd0, 16'd0, 16'd0},
            '{ROW_XFER, ACT_BYTE, 8'h0A, FLG_NONE, 1'b0, KIND_MSG, FLG_NONE, 16'd0, 16'd0, 16'd0},
            '{ROW_XFER, ACT_BYTE, 8'h00, FLG_NONE, 1'b0, KIND_MSG, FLG_NONE, 16'd0, 16'd0, 16'd0},
            '{ROW_SETTERM, ACT_BYTE, 8'hFF, FLG_NONE, 1'b0, KIND_MSG, FLG_NONE,
              16'd0, 16'd0, 16'd0},
            '{ROW_XFER, ACT_BYTE, 8'h00, FLG_NONE, 1'b0, KIND_MSG, FLG_NONE, 16'd0, 16'd0, 16'd0},
            '{ROW_XFER, ACT_BYTE, 8'hFF, FLG_NONE, 1'b0, KIND_MSG, FLG_NONE, 16'd0, 16'd0, 16'd0},
            '{ROW_SETTERM, ACT_BYTE, 8'h0A, FLG_NONE, 1'b0, KIND_MSG, FLG_NONE,
              16'd0, 16'd0, 16'd0}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        apb_access(1'b0, TERM_RESET);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == ROW_SETTERM) begin
                set_terminator(dir_rows[i].data);
            end else begin
                row_res             = '0;
                row_res.kind        = dir_rows[i].t_kind;
                row_res.flag_bits   = dir_rows[i].t_flags;
                row_res.frame_cnt   = dir_rows[i].t_f;
                row_res.overrun_cnt = dir_rows[i].t_o;
                row_res.parity_cnt  = dir_rows[i].t_p;
                row_res.last        = 1'b1;
                send_xfer(dir_rows[i].act, dir_rows[i].data, dir_rows[i].errs,
                          dir_rows[i].typed, row_res);
            end
        end

        // fill the receive ring, then a dropped terminator moves it all into the message ring
        repeat (ULA_RX_DEPTH - 1) send_xfer(ACT_BYTE, rand_byte_except(8'h0A, 8'h5A), FLG_NONE);
        send_xfer(ACT_BYTE, 8'h0A, FLG_NONE);
        // error clears the receive side only; the full message ring stays
        send_xfer(ACT_BYTE, 8'($urandom_range(0, 255)), 3'($urandom_range(1, 7)));
        send_xfer(ACT_BYTE, 8'h5A, FLG_NONE);
        send_xfer(ACT_BYTE, 8'h5A, FLG_NONE);
        // several terminators in one drain, more results than the cap allows
        set_terminator(8'h5A);
        send_xfer(ACT_BYTE, 8'h5A, FLG_NONE);
        set_terminator(8'h0A);

        next_term = 8'h0A;
        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) set_terminator(next_term);
            gaps_on   = (ph != 2);
            next_term = 8'($urandom_range(0, 255));
            sent_ph   = 0;
            while (sent_ph < 25) begin
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    send_xfer(ACT_CLEAR, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
                    sent_ph++;
                end else if (pick < 14) begin
                    send_xfer(ACT_BYTE, 8'($urandom_range(0, 255)), 3'($urandom_range(1, 7)));
                    sent_ph++;
                end else if (pick < 20) begin
                    send_xfer(ACT_BYTE, 8'($urandom_range(0, 255)), FLG_NONE);
                    sent_ph++;
                end else begin
                    len = $urandom_range(0, 12);
                    repeat (len) send_xfer(ACT_BYTE, rand_byte_except(term_m, term_m), FLG_NONE);
                    send_xfer(ACT_BYTE, term_m, FLG_NONE);
                    sent_ph += len + 1;
                end
            end
            // unfinished tail holding copies of the next terminator value
            repeat ($urandom_range(1, 4)) begin
                b = $urandom_range(0, 1) ? next_term : rand_byte_except(term_m, term_m);
                if (b == term_m) b = rand_byte_except(term_m, term_m);
                send_xfer(ACT_BYTE, b, FLG_NONE);
            end
        end

        wait_drained();
        $display("Run: %0d input transfers, %0d result transfers compared.",
                 xfers_sent, results_checked);
        $display("Covered: error kinds, clears, full rings, result cap, terminators 0x00/0xFF/random.");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ula_pkg.sv
rtl/uart_line_assembler_core.sv
sim/tb_top.sv
